FILE: rtl/rbpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbpc_pkg;

   // default sizes of the line store and the image
   localparam int MAX_ROW_BYTES_DEF = 8;
   localparam int MAX_ROWS_DEF      = 64;
   // rows in one display page
   localparam int PAGE_ROWS         = 8;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_FIRST_PAGE   = 2'd2,
      REG_FIRST_COLUMN = 2'd3
   } reg_index_type;

   // reset values of the registers
   localparam logic [6:0] IMAGE_WIDTH_RESET  = 7'd64;
   localparam logic [6:0] IMAGE_HEIGHT_RESET = 7'd64;
   localparam logic [7:0] FIRST_PAGE_RESET   = 8'd0;
   localparam logic [7:0] FIRST_COLUMN_RESET = 8'd0;

   // controller to datapath
   typedef struct packed {
      logic step;   // input transfer: store byte, advance counters
      logic rd;     // read one byte column of the line store
      logic emit;   // load the next column byte into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic band_end;   // the byte now offered completes a band
      logic out_free;   // output register can take a new column byte
      logic last_bit;   // column within the current byte is the eighth
      logic last_byte;  // current byte column is the last of the row
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/rbpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rbpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rbpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rbpc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire rbpc_pkg::status_type status,
   output rbpc_pkg::cmd_type        cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.step = req_valid;
            if (req_valid && status.band_end) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_bit) begin
                  state_in = status.last_byte ? ST_IDLE : ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

   // a line store read is always followed by a cycle that may emit
   a_read_then_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> (state_ff == ST_EMIT))
      else $error("read not followed by emit state");

endmodule

`default_nettype wire

FILE: rtl/rbpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rbpc_datapath #(
   parameter int MAX_ROW_BYTES = rbpc_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_ROWS      = rbpc_pkg::MAX_ROWS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbpc_pkg::cmd_type    cmd,
   output rbpc_pkg::status_type      status,
   input  wire logic [6:0]           image_width,
   input  wire logic [6:0]           image_height,
   input  wire logic [7:0]           first_page,
   input  wire logic [7:0]           first_column,
   input  wire logic [7:0]           req_pixel_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_column_byte,
   output logic [7:0]                rsp_page_address,
   output logic [7:0]                rsp_column_address,
   output logic                      rsp_cursor_error,
   output logic                      rsp_last_of_page,
   output logic                      rsp_last_of_image
);

   localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam logic [6:0] MAX_W = 7'(MAX_ROW_BYTES * 8);
   localparam logic [6:0] MAX_H = 7'(MAX_ROWS);
   localparam int PR = rbpc_pkg::PAGE_ROWS;

   // row counters
   logic [2:0] byte_in_row_ff, byte_in_row_in;
   logic [6:0] row_count_ff, row_count_in;

   // band being sent
   logic [3:0]    burst_h_ff;
   logic [3:0]    burst_nbytes_ff;
   logic [7:0]    burst_page_ff;
   logic          burst_last_row_ff;
   logic [AW-1:0] col_byte_ff;
   logic [2:0]    col_bit_ff;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] column_byte_ff, page_address_ff, column_address_ff;
   logic       cursor_error_ff, last_of_page_ff, last_of_image_ff;

   logic [6:0] width_c, height_c;
   logic [7:0] width_sum;
   logic [3:0] nbytes;
   logic       row_done, last_row, band_end;
   logic [7:0] page_now;
   logic [7:0] row_data [PR];
   logic [7:0] column_value;

   // clamp configuration to the supported range
   always_comb begin
      width_c   = (image_width == 7'd0) ? 7'd1 :
                  (image_width > MAX_W) ? MAX_W : image_width;
      height_c  = (image_height == 7'd0) ? 7'd1 :
                  (image_height > MAX_H) ? MAX_H : image_height;
      width_sum = {1'b0, width_c} + 8'd7;
      nbytes    = width_sum[6:3];
      row_done  = !(({1'b0, byte_in_row_ff} + 4'd1) < nbytes);
      last_row  = (({1'b0, row_count_ff} + 8'd1) >= {1'b0, height_c});
      band_end  = row_done && (last_row || (row_count_ff[2:0] == 3'(PR - 1)));
      page_now  = first_page + {4'd0, row_count_ff[6:3]};
   end

   always_comb begin
      byte_in_row_in = byte_in_row_ff;
      row_count_in   = row_count_ff;
      if (cmd.step) begin
         if (!row_done) begin
            byte_in_row_in = byte_in_row_ff + 3'd1;
         end else begin
            byte_in_row_in = 3'd0;
            row_count_in   = (band_end && last_row) ? 7'd0 : row_count_ff + 7'd1;
         end
      end
   end

   // one line store lane per band row, all read at the same byte column
   for (genvar r = 0; r < PR; r++) begin : g_lane
      rbpc_ram #(
         .WIDTH (8),
         .DEPTH (MAX_ROW_BYTES)
      ) u_lane (
         .clock   (clock),
         .wr_en   (cmd.step && (row_count_ff[2:0] == 3'(r))),
         .wr_addr (byte_in_row_ff[AW-1:0]),
         .wr_data (req_pixel_byte),
         .rd_en   (cmd.rd),
         .rd_addr (col_byte_ff),
         .rd_data (row_data[r])
      );
   end

   // gather one pixel column, rows past the band height read as zero
   always_comb begin
      for (int r = 0; r < PR; r++) begin
         column_value[r] = row_data[r][3'd7 - col_bit_ff] && (4'(r) < burst_h_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_row_ff <= 3'd0;
         row_count_ff   <= 7'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_in_row_ff <= byte_in_row_in;
         row_count_ff   <= row_count_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && band_end) begin
         burst_h_ff        <= {1'b0, row_count_ff[2:0]} + 4'd1;
         burst_nbytes_ff   <= nbytes;
         burst_page_ff     <= page_now;
         burst_last_row_ff <= last_row;
         col_byte_ff       <= '0;
         col_bit_ff        <= 3'd0;
      end
      if (cmd.emit) begin
         col_bit_ff        <= col_bit_ff + 3'd1;
         if (status.last_bit) begin
            col_byte_ff    <= col_byte_ff + AW'(1);
         end
         column_byte_ff    <= column_value;
         page_address_ff   <= burst_page_ff;
         column_address_ff <= first_column + 8'({col_byte_ff, col_bit_ff});
         cursor_error_ff   <= (burst_page_ff > 8'd7) || first_column[7];
         last_of_page_ff   <= status.last_bit && status.last_byte;
         last_of_image_ff  <= status.last_bit && status.last_byte && burst_last_row_ff;
      end
   end

   assign status.band_end  = band_end;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last_bit  = (col_bit_ff == 3'd7);
   assign status.last_byte = ((4'(col_byte_ff) + 4'd1) >= burst_nbytes_ff);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_byte    = column_byte_ff;
   assign rsp_page_address   = page_address_ff;
   assign rsp_column_address = column_address_ff;
   assign rsp_cursor_error   = cursor_error_ff;
   assign rsp_last_of_page   = last_of_page_ff;
   assign rsp_last_of_image  = last_of_image_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("column byte loaded over a stalled result");

   a_step_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !(cmd.rd || cmd.emit))
      else $error("input transfer during a burst");

   a_image_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_of_image_ff) |-> last_of_page_ff)
      else $error("image end without page end");

endmodule

`default_nettype wire

FILE: rtl/row_bitmap_to_page_columns.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      payload
// req_      in         req_valid / req_stall          req_pixel_byte
// rsp_      out        rsp_valid / rsp_stall          column byte, page, column, flags
// csr_      in         csr_psel/penable/pwrite/pready csr_paddr, csr_pwdata, csr_prdata
//
// a pixel byte that does not end a band is taken without raising req_stall
// a byte that ends a band starts a burst of ceil(width/8)*8 column bytes: for every
//   eight columns, one line store read, then eight output loads, each held while the
//   result side stalls; req_stall stays high for the burst
// the line store is eight lanes, one per band row, read one byte column at a time
// reset is synchronous: counters, controller and result valid clear, the line
//   store keeps whatever it held
// rsp_ is registered, so the last column byte may wait while input transfers resume

module row_bitmap_to_page_columns #(
   parameter int MAX_ROW_BYTES = rbpc_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_ROWS      = rbpc_pkg::MAX_ROWS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_pixel_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_column_byte,
   output logic [7:0]       rsp_page_address,
   output logic [7:0]       rsp_column_address,
   output logic             rsp_cursor_error,
   output logic             rsp_last_of_page,
   output logic             rsp_last_of_image,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration registers
   logic [6:0] image_width_ff;
   logic [6:0] image_height_ff;
   logic [7:0] first_page_ff;
   logic [7:0] first_column_ff;

   logic [1:0] csr_index;
   logic       csr_write;

   rbpc_pkg::cmd_type    cmd;
   rbpc_pkg::status_type status;

   // registers sit on word addresses, the byte offset is ignored
   assign csr_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rbpc_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= rbpc_pkg::IMAGE_HEIGHT_RESET;
         first_page_ff   <= rbpc_pkg::FIRST_PAGE_RESET;
         first_column_ff <= rbpc_pkg::FIRST_COLUMN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rbpc_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[6:0];
            rbpc_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[6:0];
            rbpc_pkg::REG_FIRST_PAGE:   first_page_ff   <= csr_pwdata[7:0];
            rbpc_pkg::REG_FIRST_COLUMN: first_column_ff <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // read back, zero above each register's width
   always_comb begin
      case (csr_index)
         rbpc_pkg::REG_IMAGE_WIDTH:  csr_prdata = {25'd0, image_width_ff};
         rbpc_pkg::REG_IMAGE_HEIGHT: csr_prdata = {25'd0, image_height_ff};
         rbpc_pkg::REG_FIRST_PAGE:   csr_prdata = {24'd0, first_page_ff};
         rbpc_pkg::REG_FIRST_COLUMN: csr_prdata = {24'd0, first_column_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // sequencer: idle taking transfers, then read / emit until the band is out
   rbpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // counters, line store, column gather and the output register
   rbpc_datapath #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_ROWS      (MAX_ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .image_width        (image_width_ff),
      .image_height       (image_height_ff),
      .first_page         (first_page_ff),
      .first_column       (first_column_ff),
      .req_pixel_byte     (req_pixel_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_column_byte    (rsp_column_byte),
      .rsp_page_address   (rsp_page_address),
      .rsp_column_address (rsp_column_address),
      .rsp_cursor_error   (rsp_cursor_error),
      .rsp_last_of_page   (rsp_last_of_page),
      .rsp_last_of_image  (rsp_last_of_image)
   );

endmodule

`default_nettype wire
